/* rtl/bpa_pkg.sv */
// Package: constants, types and field layout of the buddy page allocator.
`default_nettype none
package bpa_pkg;
  localparam int unsigned NodeSlots   = 1024;
  localparam int unsigned TopLevel    = 40;
  localparam int unsigned AddressBits = 48;
  localparam int unsigned IdxW        = $clog2(NodeSlots);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned LinkW       = 32;
  localparam int unsigned SizeW       = 41;
  localparam logic [5:0]  MinLevel    = 6'd12;
  localparam logic [5:0]  MaxLevel    = 6'(TopLevel);

  localparam int unsigned BFree   = 6;
  localparam int unsigned BSplit  = 7;
  localparam int unsigned BWas    = 8;
  localparam int unsigned BHasPar = 9;
  localparam int unsigned BSide   = 10;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, S_SCAN, S_SCAN_W, S_SPLIT_RD, S_SPLIT_CHK,
    S_CSCAN, S_CSCAN_W, S_REUSE0, S_REUSE1, S_NEW0, S_NEW1, S_PARENT,
    S_GRANT, S_FSCAN, S_FSCAN_W, S_FSET, S_M_RDT, S_M_WT, S_M_CHK,
    S_M_RDP, S_M_WP, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]             op;
    logic [AddressBits-1:0] address;
    logic [5:0]             block_level;
    logic [SizeW-1:0]       request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [AddressBits-1:0] granted_address;
    logic [SizeW-1:0]       granted_size;
  } rsp_t;
endpackage
`default_nettype wire

/* rtl/bpa_if.sv */
// Interfaces: valid/ready channels for requests and responses.
`default_nettype none
interface bpa_req_if;
  import bpa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/bpa_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write or read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

/* rtl/buddy_page_allocator_core.sv */
// Top level: buddy page allocator over a node table held in two RAMs.
// Throughput: one transaction at a time; the next is taken after the result
// has left the output register. Each table scan reads an entry and compares
// it once the registered RAM read returns. Reset clears the state, the node
// count and the response valid flag; the RAMs need none.
`default_nettype none
module buddy_page_allocator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;     // scan pointer
  logic [IdxW-1:0] n_q, n_d;         // current node
  logic [IdxW-1:0] t_q, t_d;         // twin / child
  logic            found_q, found_d;
  logic [5:0]      best_q, best_d;
  logic [AddressBits-1:0] naddr_q, naddr_d;
  logic [LinkW-1:0]       nlink_q, nlink_d;
  rsp_t            rsp_q, rsp_d;
  logic            rv_q, rv_d;

  logic                   we;
  logic [IdxW-1:0]        ra;
  logic [AddressBits-1:0] wa_data, ra_data;
  logic [LinkW-1:0]       wl_data, rl_data;
  logic                   wa_en;

  bpa_ram #(.Width(AddressBits), .Depth(NodeSlots)) u_addr (
    .clk_i, .we_i(wa_en), .addr_i(ra), .wdata_i(wa_data), .rdata_o(ra_data));
  bpa_ram #(.Width(LinkW), .Depth(NodeSlots)) u_link (
    .clk_i, .we_i(we), .addr_i(ra), .wdata_i(wl_data), .rdata_o(rl_data));

  // effective request size (at least one page) and level comparisons
  logic [SizeW-1:0] rsize;
  logic [5:0]       rl_lvl, n_lvl;
  logic [SizeW:0]   rl_sz;
  assign rsize   = (req_q.request_size < SizeW'(4096)) ? SizeW'(4096) : req_q.request_size;
  assign rl_lvl  = rl_data[5:0];
  assign n_lvl   = nlink_q[5:0];
  assign rl_sz   = (rl_lvl > 6'(SizeW)) ? '1 : ((SizeW+1)'(1) << rl_lvl);

  function automatic logic [LinkW-1:0] mk_link(logic [5:0] l, logic hp, logic sd,
                                               logic [IdxW-1:0] p);
    logic [LinkW-1:0] v;
    v = '0;
    v[5:0] = l;
    v[BFree] = 1'b1;
    v[BHasPar] = hp;
    v[BSide] = sd;
    v[16 +: IdxW] = p;
    return v;
  endfunction

  // sequence adds, allocation scans and splits, frees and merges
  always_comb begin
    logic [CntW-1:0] idx_ext;
    logic [IdxW-1:0] tw;
    state_d = state_q; req_d = req_q; cnt_d = cnt_q; idx_d = idx_q;
    n_d = n_q; t_d = t_q; found_d = found_q; best_d = best_q;
    naddr_d = naddr_q; nlink_d = nlink_q; rsp_d = rsp_q; rv_d = rv_q;
    we = 1'b0; wa_en = 1'b0; ra = idx_q; wa_data = naddr_q; wl_data = nlink_q;
    idx_ext = {1'b0, idx_q};
    tw = rl_data[BSide] ? n_q - 1'b1 : n_q + 1'b1;
    req_i.ready = (state_q == S_IDLE) && !rv_q;
    if (rv_q && rsp_o.ready) rv_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid && !rv_q) begin
          req_d = req_i.data;
          rsp_d = '0;
          idx_d = '0;
          found_d = 1'b0;
          case (op_e'(req_i.data.op))
            OP_ADD:   state_d = S_ADD;
            OP_ALLOC: state_d = (cnt_q == '0) ? S_DONE : S_SCAN;
            OP_FREE:  state_d = (cnt_q == '0) ? S_DONE : S_FSCAN;
            default:  state_d = S_DONE;
          endcase
          if (cnt_q == '0 && op_e'(req_i.data.op) == OP_ALLOC) rsp_d.status = ST_NO_MEM;
          if (cnt_q == '0 && op_e'(req_i.data.op) == OP_FREE) rsp_d.status = ST_NOT_FOUND;
        end
      end
      S_ADD: begin
        if (cnt_q >= CntW'(NodeSlots)) begin
          rsp_d.status = ST_FULL;
        end else begin
          ra = cnt_q[IdxW-1:0];
          we = 1'b1; wa_en = 1'b1;
          wa_data = req_q.address;
          wl_data = mk_link((req_q.block_level < MinLevel) ? MinLevel :
                            (req_q.block_level > MaxLevel) ? MaxLevel : req_q.block_level,
                            1'b0, 1'b0, '0);
          cnt_d = cnt_q + 1'b1;
        end
        state_d = S_DONE;
      end
      // best-fit scan: read, then compare
      S_SCAN: state_d = S_SCAN_W;
      S_SCAN_W: begin
        if (rl_data[BFree] && rl_sz >= {1'b0, rsize} && (!found_q || rl_lvl < best_q)) begin
          found_d = 1'b1; best_d = rl_lvl; n_d = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (idx_ext + 1'b1 >= cnt_q) begin
          if (!found_d) begin
            rsp_d.status = ST_NO_MEM; state_d = S_DONE;
          end else begin
            state_d = S_SPLIT_RD;
          end
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SPLIT_RD: begin
        ra = n_q; state_d = S_SPLIT_CHK;
      end
      S_SPLIT_CHK: begin
        ra = n_q;
        naddr_d = ra_data; nlink_d = rl_data;
        if (rl_lvl > MinLevel &&
            ((rl_lvl - 6'd1 > 6'(SizeW)) || ((SizeW+1)'(1) << (rl_lvl - 6'd1)) >= {1'b0, rsize})) begin
          idx_d = '0;
          if (rl_data[BWas]) state_d = S_CSCAN;
          else state_d = S_NEW0;
        end else begin
          state_d = S_GRANT;
        end
      end
      // look for an earlier low child of this node
      S_CSCAN: state_d = S_CSCAN_W;
      S_CSCAN_W: begin
        idx_d = idx_q + 1'b1;
        if (rl_data[BHasPar] && rl_data[16 +: IdxW] == n_q && rl_data[LinkW-1 -: (16-IdxW)] == '0
            && !rl_data[BSide] && (idx_ext + 1'b1 < cnt_q)) begin
          t_d = idx_q; state_d = S_REUSE0;
        end else if (idx_ext + 1'b1 >= cnt_q) begin
          state_d = S_NEW0;
        end else begin
          state_d = S_CSCAN;
        end
      end
      S_REUSE0: begin
        // child link is still on the read port; keep the parent link held
        ra = t_q; we = 1'b1;
        wl_data = rl_data; wl_data[BFree] = 1'b1;
        state_d = S_REUSE1;
        idx_d = t_q + 1'b1;
      end
      S_REUSE1: begin
        ra = idx_q;             // read twin, then set its free mark
        state_d = S_NEW1;
        t_d = t_q;
      end
      S_NEW0: begin
        if (cnt_q + 2'd2 > CntW'(NodeSlots)) begin
          rsp_d.status = ST_FULL; state_d = S_DONE;
        end else begin
          ra = cnt_q[IdxW-1:0]; we = 1'b1; wa_en = 1'b1;
          wa_data = naddr_q;
          wl_data = mk_link(n_lvl - 6'd1, 1'b1, 1'b0, n_q);
          t_d = cnt_q[IdxW-1:0];
          cnt_d = cnt_q + 1'b1;
          state_d = S_PARENT;
          ra = cnt_q[IdxW-1:0];
          idx_d = '1;           // marks the fresh-pair path
        end
      end
      S_NEW1: begin
        // twin of a reused child: rewrite with free set
        ra = idx_q; we = 1'b1;
        wl_data = rl_data; wl_data[BFree] = 1'b1;
        state_d = S_PARENT;
        idx_d = '0;
      end
      S_PARENT: begin
        if (idx_q == '1) begin
          // write the high half of a fresh pair
          ra = cnt_q[IdxW-1:0]; we = 1'b1; wa_en = 1'b1;
          wa_data = naddr_q + (AddressBits'(1) << (n_lvl - 6'd1));
          wl_data = mk_link(n_lvl - 6'd1, 1'b1, 1'b1, n_q);
          cnt_d = cnt_q + 1'b1;
          idx_d = '0;
        end else begin
          ra = n_q; we = 1'b1;
          wl_data = nlink_q;
          wl_data[BSplit] = 1'b1; wl_data[BFree] = 1'b0; wl_data[BWas] = 1'b1;
          n_d = t_q;
          state_d = S_SPLIT_RD;
        end
      end
      S_GRANT: begin
        ra = n_q; we = 1'b1;
        wl_data = nlink_q; wl_data[BFree] = 1'b0;
        rsp_d.granted_address = naddr_q;
        rsp_d.granted_size = (n_lvl >= 6'(SizeW)) ? '0 : (SizeW'(1) << n_lvl);
        state_d = S_DONE;
      end
      // find first unsplit node at the address
      S_FSCAN: state_d = S_FSCAN_W;
      S_FSCAN_W: begin
        idx_d = idx_q + 1'b1;
        if (ra_data == req_q.address && !rl_data[BSplit]) begin
          n_d = idx_q; nlink_d = rl_data; state_d = S_FSET;
        end else if (idx_ext + 1'b1 >= cnt_q) begin
          rsp_d.status = ST_NOT_FOUND; state_d = S_DONE;
        end else begin
          state_d = S_FSCAN;
        end
      end
      S_FSET: begin
        ra = n_q; we = 1'b1;
        wl_data = nlink_q; wl_data[BFree] = 1'b1;
        nlink_d = wl_data;
        state_d = S_M_RDT;
      end
      // merge: read twin, check, clear both, update parent
      S_M_RDT: begin
        tw = nlink_q[BSide] ? n_q - 1'b1 : n_q + 1'b1;
        t_d = tw; ra = tw;
        if (!nlink_q[BHasPar] || ({1'b0, tw} >= cnt_q) || (nlink_q[BSide] && n_q == '0)
            || (!nlink_q[BSide] && n_q == '1)) state_d = S_DONE;
        else state_d = S_M_CHK;
      end
      S_M_CHK: begin
        ra = t_q;
        if (!nlink_q[BFree] || !rl_data[BFree] || nlink_q[LinkW-1 -: (16-IdxW)] != '0
            || {1'b0, nlink_q[16 +: IdxW]} >= cnt_q) begin
          state_d = S_DONE;
        end else begin
          we = 1'b1; wl_data = rl_data; wl_data[BFree] = 1'b0;
          state_d = S_M_WT;
        end
      end
      S_M_WT: begin
        ra = n_q; we = 1'b1;
        wl_data = nlink_q; wl_data[BFree] = 1'b0;
        n_d = nlink_q[16 +: IdxW];
        state_d = S_M_RDP;
      end
      S_M_RDP: begin
        ra = n_q; state_d = S_M_WP;
      end
      S_M_WP: begin
        ra = n_q; we = 1'b1;
        wl_data = rl_data;
        wl_data[BSplit] = 1'b0; wl_data[BWas] = 1'b1; wl_data[BFree] = 1'b1;
        nlink_d = wl_data;
        state_d = S_M_RDT;
      end
      S_DONE: begin
        if (!rv_q) begin
          rv_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold control state and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; idx_q <= idx_d; n_q <= n_d; t_q <= t_d; found_q <= found_d;
    best_q <= best_d; naddr_q <= naddr_d; nlink_q <= nlink_d; rsp_q <= rsp_d;
  end

  assign rsp_o.valid = rv_q;
  assign rsp_o.data  = rsp_q;
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench: directed table, random traffic and a table fill for the buddy page allocator, checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import bpa_pkg::*;

  logic clk_i;
  logic rst_ni;

  bpa_req_if req_bus ();
  bpa_rsp_if rsp_bus ();

  buddy_page_allocator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  localparam int unsigned StallLimit = 400000;
  localparam int unsigned HoldOffLen = 300;
  localparam int unsigned RandomItems = 290;
  localparam int unsigned CalmItems = 40;

  // predictor copy of the node table
  logic [AddressBits-1:0] node_addr [NodeSlots];
  logic [5:0]             node_lvl [NodeSlots];
  logic                   node_free [NodeSlots];
  logic                   node_split [NodeSlots];
  logic                   node_was [NodeSlots];
  logic                   node_haspar [NodeSlots];
  logic                   node_side [NodeSlots];
  logic [15:0]            node_parent [NodeSlots];
  int unsigned            node_total;

  rsp_t        pending_rsp [$];
  int unsigned mismatches;
  logic        calm;
  logic        hold_off_req;

  typedef struct {
    op_e                    op;
    logic [AddressBits-1:0] address;
    logic [5:0]             block_level;
    logic [SizeW-1:0]       request_size;
    bit                     typed;
    status_e                status;
    logic [AddressBits-1:0] granted_address;
    logic [SizeW-1:0]       granted_size;
  } row_t;

  // clock; reset is driven by the stimulus block
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned push_node(input logic [AddressBits-1:0] a, input logic [5:0] l,
                                            input logic hp, input int unsigned par,
                                            input logic sd);
    int unsigned i;
    i = node_total;
    node_total++;
    node_addr[i] = a;
    node_lvl[i] = l;
    node_free[i] = 1'b1;
    node_split[i] = 1'b0;
    node_was[i] = 1'b0;
    node_haspar[i] = hp;
    node_side[i] = sd;
    node_parent[i] = par[15:0];
    return i;
  endfunction

  // merge free twins upward into their parents
  function automatic void merge_twins(input int unsigned start);
    int unsigned n;
    int unsigned t;
    int unsigned p;
    n = start;
    forever begin
      if (!node_haspar[n]) return;
      t = node_side[n] ? n - 1 : n + 1;
      if (t >= node_total || !node_free[n] || !node_free[t]) return;
      p = node_parent[n];
      if (p >= node_total) return;
      node_free[n] = 1'b0;
      node_free[t] = 1'b0;
      node_split[p] = 1'b0;
      node_was[p] = 1'b1;
      node_free[p] = 1'b1;
      n = p;
    end
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    rsp_t        p;
    logic [5:0]  l;
    logic [63:0] want;
    logic [63:0] best;
    logic [63:0] sz;
    bit          found;
    bit          have;
    int unsigned n;
    int unsigned child;
    int unsigned i;
    logic [5:0]  cl;
    p = '0;
    case (op_e'(r.op))
      OP_ADD: begin
        if (node_total >= NodeSlots) begin
          p.status = ST_FULL;
        end else begin
          l = r.block_level;
          if (l < MinLevel) l = MinLevel;
          if (l > MaxLevel) l = MaxLevel;
          void'(push_node(r.address, l, 1'b0, 0, 1'b0));
        end
      end
      OP_ALLOC: begin
        want = 64'(r.request_size);
        if (want < 64'd4096) want = 64'd4096;
        found = 0;
        best = 0;
        n = 0;
        for (i = 0; i < node_total; i++) begin
          sz = 64'd1 << node_lvl[i];
          if (node_free[i] && sz >= want && (!found || sz < best)) begin
            found = 1;
            best = sz;
            n = i;
          end
        end
        if (!found) begin
          p.status = ST_NO_MEM;
          return p;
        end
        // split down to the smallest level that still fits
        while (node_lvl[n] > MinLevel && (64'd1 << (node_lvl[n] - 1)) >= want) begin
          cl = node_lvl[n] - 1;
          have = 0;
          child = 0;
          if (node_was[n]) begin
            for (i = 0; i < node_total; i++) begin
              if (node_haspar[i] && node_parent[i] == n[15:0] && !node_side[i]
                  && i + 1 < node_total) begin
                child = i;
                have = 1;
                break;
              end
            end
          end
          if (have) begin
            node_free[child] = 1'b1;
            node_free[child + 1] = 1'b1;
          end else begin
            if (node_total + 2 > NodeSlots) begin
              p.status = ST_FULL;
              return p;
            end
            child = push_node(node_addr[n], cl, 1'b1, n, 1'b0);
            void'(push_node(node_addr[n] + (48'd1 << cl), cl, 1'b1, n, 1'b1));
          end
          node_split[n] = 1'b1;
          node_free[n] = 1'b0;
          node_was[n] = 1'b1;
          n = child;
        end
        node_free[n] = 1'b0;
        p.granted_address = node_addr[n];
        p.granted_size = SizeW'(64'd1 << node_lvl[n]);
      end
      OP_FREE: begin
        for (i = 0; i < node_total; i++) begin
          if (node_addr[i] == r.address && !node_split[i]) break;
        end
        if (i >= node_total) begin
          p.status = ST_NOT_FOUND;
        end else begin
          node_free[i] = 1'b1;
          merge_twins(i);
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic bit free_page_left();
    for (int unsigned i = 0; i < node_total; i++) begin
      if (node_free[i] && node_lvl[i] == MinLevel) return 1;
    end
    return 0;
  endfunction

  // offer one transaction; entered and left just after a falling edge
  task automatic send_item(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t p;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.data <= r;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    p = predict_response(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    @(negedge clk_i);
  endtask

  task automatic send_plain(input req_t r);
    send_item(r, 0, '0);
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    r.address = AddressBits'({$urandom, $urandom});
    r.block_level = 6'($urandom_range(12, 16));
    if ($urandom_range(0, 9) == 0) r.block_level = 6'($urandom);
    r.request_size = SizeW'($urandom_range(0, 70000));
    if ($urandom_range(0, 9) == 0) r.request_size = SizeW'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 20 && node_total < 300) begin
      r.op = OP_ADD;
    end else if (pick < 55) begin
      r.op = OP_ALLOC;
    end else if (pick < 92) begin
      r.op = OP_FREE;
      if (node_total > 0 && $urandom_range(0, 4) != 0)
        r.address = node_addr[$urandom_range(0, node_total - 1)];
    end else begin
      r.op = OP_NONE;
    end
    return r;
  endfunction

  // response side: random stall bursts, one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        rsp_bus.ready <= 1'b0;
        repeat (HoldOffLen) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (calm) begin
        rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // check results and watch for a hang
  initial begin
    int unsigned idle;
    rsp_t        e;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
        idle = 0;
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result", 64'(rsp_bus.data), 0);
        end else begin
          e = pending_rsp.pop_front();
          if (rsp_bus.data.status !== e.status)
            report_mismatch("status", 64'(rsp_bus.data.status), 64'(e.status));
          if (rsp_bus.data.granted_address !== e.granted_address)
            report_mismatch("granted_address", 64'(rsp_bus.data.granted_address),
                            64'(e.granted_address));
          if (rsp_bus.data.granted_size !== e.granted_size)
            report_mismatch("granted_size", 64'(rsp_bus.data.granted_size),
                            64'(e.granted_size));
        end
      end else if (rst_ni && req_bus.valid && req_bus.ready) begin
        idle = 0;
      end else begin
        idle++;
        if (idle >= StallLimit) begin
          $display("watchdog expired");
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t rows [$];
    row_t w;
    req_t r;
    rsp_t t;

    mismatches = 0;
    node_total = 0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.data = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: empty table, saturation, wrap of a high child, re-free
    rows = '{
      '{OP_FREE,  48'h0,            6'd12, 41'd0,   1, ST_NOT_FOUND, 48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd12, 41'd0,   1, ST_NO_MEM,    48'h0, 41'd0},
      '{OP_NONE,  48'hFFFFFFFFFFFF, 6'd63, 41'h1FFFFFFFFFF, 1, ST_OK, 48'h0, 41'd0},
      '{OP_ADD,   48'h10000,        6'd5,  41'd0,   1, ST_OK,        48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd0,  41'd0,   1, ST_OK,    48'h10000, 41'd4096},
      '{OP_ALLOC, 48'h0,            6'd0,  41'd1,   1, ST_NO_MEM,    48'h0, 41'd0},
      '{OP_FREE,  48'h10000,        6'd0,  41'd0,   1, ST_OK,        48'h0, 41'd0},
      '{OP_FREE,  48'h10000,        6'd0,  41'd0,   1, ST_OK,        48'h0, 41'd0},
      '{OP_ADD,   48'hFFFFFFFFFFFF, 6'd63, 41'd0,   1, ST_OK,        48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd0,  41'd4097, 0, ST_OK,       48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd0,  41'h10000000000, 0, ST_OK, 48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd0,  41'h1FFFFFFFFFF, 1, ST_NO_MEM, 48'h0, 41'd0},
      '{OP_FREE,  48'h000000000FFF, 6'd0,  41'd0,   0, ST_OK,        48'h0, 41'd0},
      '{OP_FREE,  48'hFFFFFFFFFFFF, 6'd0,  41'd0,   0, ST_OK,        48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd0,  41'h10000000000, 0, ST_OK, 48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd0,  41'd5000, 0, ST_OK,       48'h0, 41'd0},
      '{OP_FREE,  48'hFFFFFFFFFFFF, 6'd0,  41'd0,   0, ST_OK,        48'h0, 41'd0},
      '{OP_FREE,  48'h123456789ABC, 6'd0,  41'd0,   1, ST_NOT_FOUND, 48'h0, 41'd0},
      '{OP_ADD,   48'h0,            6'd40, 41'd0,   1, ST_OK,        48'h0, 41'd0},
      '{OP_ALLOC, 48'h0,            6'd0,  41'd4096, 0, ST_OK,       48'h0, 41'd0},
      '{OP_FREE,  48'h0,            6'd0,  41'd0,   0, ST_OK,        48'h0, 41'd0}
    };
    foreach (rows[k]) begin
      w = rows[k];
      r.op = w.op;
      r.address = w.address;
      r.block_level = w.block_level;
      r.request_size = w.request_size;
      t.status = w.status;
      t.granted_address = w.granted_address;
      t.granted_size = w.granted_size;
      send_item(r, w.typed, t);
    end

    // random traffic with one long receiver hold-off and one drain pause
    for (int unsigned k = 0; k < RandomItems; k++) begin
      if (k == 100) hold_off_req = 1'b1;
      if (k == 200) begin
        req_bus.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk_i);
      end
      if (k == RandomItems - CalmItems) calm = 1'b1;
      send_plain(random_request());
    end

    // use up free pages, then fill the table so splits and adds run out of slots
    r = '0;
    r.op = OP_ALLOC;
    r.request_size = 41'd4096;
    while (free_page_left()) send_plain(r);
    r.op = OP_ADD;
    r.block_level = 6'd13;
    while (node_total < NodeSlots - 1) begin
      r.address = AddressBits'({$urandom, $urandom});
      send_plain(r);
    end
    r.op = OP_ALLOC;
    r.request_size = 41'd4096;
    send_plain(r);
    r.op = OP_ADD;
    send_plain(r);
    send_plain(r);
    r.op = OP_ALLOC;
    send_plain(r);
    r.op = OP_FREE;
    r.address = node_addr[NodeSlots - 1];
    send_plain(r);
    req_bus.valid <= 1'b0;

    // drain and let the block settle
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (4 * NodeSlots) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator_core.sv
tb/testbench.sv
